/* rtl/gcbb_pkg.sv */
`default_nettype none
package gcbb_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned REG_DATA_W = 16;

  localparam logic [REG_IDX_W-1:0] REG_ATLAS_W = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ATLAS_H = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CELL_W = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CELL_H = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COLUMNS = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COV_TH = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SOLID = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_ADV_SCALE = 3'd7;

  // reset cell size, also the box start values right after reset
  localparam logic [8:0] CELL_W_RST = 9'd32;
  localparam logic [8:0] CELL_H_RST = 9'd32;

  // box summary handed from the scan front to the metric back end
  typedef struct packed {
    logic [6:0]  glyph_index;
    logic        is_empty;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [8:0]  box_min_x;
    logic [7:0]  box_max_x;
    logic [8:0]  box_min_y;
    logic [7:0]  box_max_y;
    logic [8:0]  solid_min_x;
    logic [8:0]  solid_min_y;
  } cell_sum_t;

  // effective sizes after clamping zero to one and large values to maxima
  typedef struct packed {
    logic [12:0] aw;
    logic [12:0] ah;
    logic [8:0]  cw;
    logic [8:0]  ch;
    logic [15:0] adv_scale;
  } geom_t;

  typedef struct packed {
    logic [6:0]  glyph_index;
    logic        is_empty;
    logic [27:0] u_pos;
    logic [27:0] v_pos;
    logic [16:0] u_size;
    logic [24:0] v_size;
    logic [16:0] width_ratio;
    logic [16:0] height_ratio;
    logic [16:0] bearing_left;
    logic [16:0] bearing_top;
    logic [16:0] offset_down;
    logic [20:0] advance;
  } glyph_rec_t;

endpackage
`default_nettype wire

/* rtl/gcbb_scan.sv */
`default_nettype none
module gcbb_scan #(
  parameter int unsigned GLYPH_COUNT = 128
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          sample_i,
  input  wire logic [8:0]          cw_i,
  input  wire logic [8:0]          ch_i,
  input  wire logic [7:0]          cols_i,
  input  wire logic [7:0]          cov_th_i,
  input  wire logic [7:0]          solid_i,
  output logic                     sum_valid_o,
  input  wire logic                sum_ready_i,
  output gcbb_pkg::cell_sum_t      sum_o
);

  logic [7:0] x_q, y_q;
  logic [6:0] glyph_q, col_q;
  logic [11:0] ox_q, oy_q;
  logic [8:0] bminx_q, bminy_q, sminx_q, sminy_q;
  logic [7:0] bmaxx_q, bmaxy_q;
  logic       pend_q;
  gcbb_pkg::cell_sum_t sum_q;

  logic       take, vis, sol, col_end, cell_end;
  logic [8:0] nbminx, nbminy, nsminx, nsminy;
  logic [7:0] nbmaxx, nbmaxy;

  assign in_ready_o  = !pend_q || sum_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign sum_valid_o = pend_q;
  assign sum_o       = sum_q;

  always_comb begin
    vis = sample_i > cov_th_i;
    sol = sample_i >= solid_i;
    nbminx = (vis && {1'b0, x_q} < bminx_q) ? {1'b0, x_q} : bminx_q;
    nbminy = (vis && {1'b0, y_q} < bminy_q) ? {1'b0, y_q} : bminy_q;
    nbmaxx = (vis && x_q > bmaxx_q) ? x_q : bmaxx_q;
    nbmaxy = (vis && y_q > bmaxy_q) ? y_q : bmaxy_q;
    nsminx = (sol && {1'b0, x_q} < sminx_q) ? {1'b0, x_q} : sminx_q;
    nsminy = (sol && {1'b0, y_q} < sminy_q) ? {1'b0, y_q} : sminy_q;
    col_end  = ({1'b0, y_q} + 9'd1) >= ch_i;
    cell_end = col_end && (({1'b0, x_q} + 9'd1) >= cw_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0; y_q <= '0; glyph_q <= '0; col_q <= '0;
      ox_q <= '0; oy_q <= '0; pend_q <= 1'b0;
      bminx_q <= gcbb_pkg::CELL_W_RST; bminy_q <= gcbb_pkg::CELL_H_RST;
      sminx_q <= gcbb_pkg::CELL_W_RST; sminy_q <= gcbb_pkg::CELL_H_RST;
      bmaxx_q <= '0; bmaxy_q <= '0;
    end else begin
      pend_q <= (take && cell_end) || (pend_q && !sum_ready_i);
      if (take) begin
        y_q <= col_end ? 8'd0 : y_q + 8'd1;
        if (col_end) x_q <= cell_end ? 8'd0 : x_q + 8'd1;
        if (cell_end) begin
          // box restarts from the cell size in force at the cell end
          bminx_q <= cw_i; bminy_q <= ch_i; sminx_q <= cw_i; sminy_q <= ch_i;
          bmaxx_q <= '0; bmaxy_q <= '0;
          if ({25'd0, glyph_q} + 32'd1 >= GLYPH_COUNT) begin
            glyph_q <= '0; col_q <= '0; ox_q <= '0; oy_q <= '0;
          end else begin
            glyph_q <= glyph_q + 7'd1;
            if ({1'b0, col_q} + 8'd1 >= cols_i) begin
              col_q <= '0; ox_q <= '0;
              oy_q <= oy_q + {3'd0, ch_i};
            end else begin
              col_q <= col_q + 7'd1;
              ox_q <= ox_q + {3'd0, cw_i};
            end
          end
        end else begin
          bminx_q <= nbminx; bminy_q <= nbminy; bmaxx_q <= nbmaxx;
          bmaxy_q <= nbmaxy; sminx_q <= nsminx; sminy_q <= nsminy;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cell_end) begin
      sum_q.glyph_index <= glyph_q;
      sum_q.is_empty    <= (nbminx > {1'b0, nbmaxx}) || (nbminy > {1'b0, nbmaxy});
      sum_q.origin_x    <= ox_q;
      sum_q.origin_y    <= oy_q;
      sum_q.box_min_x   <= nbminx;
      sum_q.box_max_x   <= nbmaxx;
      sum_q.box_min_y   <= nbminy;
      sum_q.box_max_y   <= nbmaxy;
      sum_q.solid_min_x <= nsminx;
      sum_q.solid_min_y <= nsminy;
    end
  end

endmodule
`default_nettype wire

/* rtl/gcbb_fifo.sv */
`default_nettype none
module gcbb_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_valid_i,
  output logic                     wr_ready_o,
  input  wire gcbb_pkg::cell_sum_t wr_data_i,
  output logic                     rd_valid_o,
  input  wire logic                rd_ready_i,
  output gcbb_pkg::cell_sum_t      rd_data_o
);

  gcbb_pkg::cell_sum_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule
`default_nettype wire

/* rtl/gcbb_div.sv */
`default_nettype none
// restoring divider: quo = floor((num << 16) / den), one quotient bit a cycle
module gcbb_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [28:0] den_i,
  output logic             done_o,
  output logic [47:0]      quo_o
);

  logic [47:0] q_q;
  logic [29:0] r_q;
  logic [28:0] d_q;
  logic [5:0]  n_q;
  logic        busy_q;
  logic [29:0] sh;
  logic        ge;

  assign sh = {r_q[28:0], q_q[47]};
  assign ge = sh >= {1'b0, d_q};
  assign quo_o = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_o <= 1'b0; n_q <= '0;
    end else begin
      done_o <= !start_i && busy_q && (n_q == 6'd47);
      if (start_i) begin
        busy_q <= 1'b1; n_q <= 6'd0;
      end else if (busy_q) begin
        n_q <= n_q + 6'd1;
        if (n_q == 6'd47) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= {num_i, 16'd0}; r_q <= '0; d_q <= den_i;
    end else if (busy_q) begin
      r_q <= ge ? sh - {1'b0, d_q} : sh;
      q_q <= {q_q[46:0], ge};
    end
  end

endmodule
`default_nettype wire

/* rtl/gcbb_metric.sv */
`default_nettype none
module gcbb_metric (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                sum_valid_i,
  output logic                     sum_ready_o,
  input  wire gcbb_pkg::cell_sum_t sum_i,
  input  wire gcbb_pkg::geom_t     geom_i,
  output logic                     rec_valid_o,
  input  wire logic                rec_ready_i,
  output gcbb_pkg::glyph_rec_t     rec_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RUN  = 4'd1;
  localparam logic [3:0] ST_WAIT = 4'd2;
  localparam logic [3:0] ST_OUT  = 4'd3;

  localparam logic [3:0] OP_U_POS    = 4'd0;
  localparam logic [3:0] OP_V_POS    = 4'd1;
  localparam logic [3:0] OP_U_SIZE   = 4'd2;
  localparam logic [3:0] OP_V_SIZE   = 4'd3;
  localparam logic [3:0] OP_W_RATIO  = 4'd4;
  localparam logic [3:0] OP_H_RATIO  = 4'd5;
  localparam logic [3:0] OP_BEAR_L   = 4'd6;
  localparam logic [3:0] OP_BEAR_T   = 4'd7;
  localparam logic [3:0] OP_OFS_DOWN = 4'd8;
  localparam logic [3:0] OP_ADVANCE  = 4'd9;
  localparam logic [3:0] LAST_OP     = OP_ADVANCE;

  logic [3:0] st_q, op_q;
  gcbb_pkg::cell_sum_t s_q;
  gcbb_pkg::glyph_rec_t r_q, rec_init;
  logic start, done;
  logic [31:0] num;
  logic [28:0] den;
  logic [47:0] quo;
  logic [8:0] w, h;
  logic [24:0] wmul;
  logic [24:0] q_one, q_vsz, q_adv;

  function automatic logic [24:0] sat(input logic [47:0] q, input logic [24:0] cap);
    sat = (q > {23'd0, cap}) ? cap : q[24:0];
  endfunction

  gcbb_div u_div (.clk_i, .rst_ni, .start_i(start), .num_i(num), .den_i(den),
                  .done_o(done), .quo_o(quo));

  assign w = {1'b0, s_q.box_max_x} - s_q.box_min_x + 9'd1;
  assign h = {1'b0, s_q.box_max_y} - s_q.box_min_y + 9'd1;
  assign wmul = w * geom_i.adv_scale;
  assign sum_ready_o = st_q == ST_IDLE;
  assign rec_valid_o = st_q == ST_OUT;
  assign rec_o = r_q;
  assign q_one = sat(quo, 25'h10000);
  assign q_vsz = sat(quo, 25'h1000000);
  assign q_adv = sat(quo, 25'h100000);

  // one division per metric, sequenced by op_q
  always_comb begin
    num = '0; den = {16'd0, geom_i.aw};
    case (op_q)
      OP_U_POS: num = {19'd0, {1'b0, s_q.origin_x} + {4'd0, s_q.box_min_x}};
      OP_V_POS: begin num = {19'd0, {1'b0, s_q.origin_y} + {4'd0, s_q.box_min_y}};
        den = {16'd0, geom_i.ah}; end
      OP_U_SIZE: num = {23'd0, w};
      OP_V_SIZE: begin num = {23'd0, h}; den = {16'd0, geom_i.ah}; end
      OP_W_RATIO: begin num = {23'd0, w}; den = {20'd0, geom_i.cw}; end
      OP_H_RATIO: begin num = {23'd0, h}; den = {20'd0, geom_i.ch}; end
      OP_BEAR_L: begin num = {23'd0, s_q.solid_min_x - s_q.box_min_x};
        den = {20'd0, geom_i.cw}; end
      OP_BEAR_T: begin num = {23'd0, s_q.box_min_y}; den = {20'd0, geom_i.ch}; end
      OP_OFS_DOWN: begin num = {23'd0, s_q.solid_min_y - s_q.box_min_y};
        den = {20'd0, geom_i.ch}; end
      // (w * scale << 16) / (cw << 16) gives floor(w * scale / cw)
      OP_ADVANCE: begin num = {7'd0, wmul}; den = {4'd0, geom_i.cw, 16'd0}; end
      default: num = '0;
    endcase
  end

  assign start = (st_q == ST_RUN);

  // record start value; an empty cell is complete right away
  always_comb begin
    rec_init = '0;
    rec_init.glyph_index = sum_i.glyph_index;
    rec_init.is_empty = sum_i.is_empty;
    if (sum_i.is_empty) begin
      rec_init.u_pos = {sum_i.origin_x, 16'd0};
      rec_init.v_pos = {sum_i.origin_y, 16'd0};
      rec_init.v_size = {geom_i.ch, 16'd0};
      rec_init.advance = 21'd16 << 16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; op_q <= '0;
    end else begin
      case (st_q)
        ST_IDLE: if (sum_valid_i) begin
          op_q <= OP_U_POS;
          st_q <= sum_i.is_empty ? ST_OUT : ST_RUN;
        end
        ST_RUN: st_q <= ST_WAIT;
        ST_WAIT: if (done) begin
          if (op_q == LAST_OP) st_q <= ST_OUT;
          else begin op_q <= op_q + 4'd1; st_q <= ST_RUN; end
        end
        ST_OUT: if (rec_ready_i) st_q <= ST_IDLE;
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && sum_valid_i) begin
      s_q <= sum_i;
      r_q <= rec_init;
    end else if (st_q == ST_WAIT && done) begin
      case (op_q)
        OP_U_POS: r_q.u_pos <= (quo > 48'hFFFFFFF) ? 28'hFFFFFFF : quo[27:0];
        OP_V_POS: r_q.v_pos <= (quo > 48'hFFFFFFF) ? 28'hFFFFFFF : quo[27:0];
        OP_U_SIZE: r_q.u_size <= q_one[16:0];
        OP_V_SIZE: r_q.v_size <= q_vsz;
        OP_W_RATIO: r_q.width_ratio <= q_one[16:0];
        OP_H_RATIO: r_q.height_ratio <= q_one[16:0];
        OP_BEAR_L: r_q.bearing_left <= (s_q.solid_min_x > s_q.box_min_x) ?
                                       q_one[16:0] : 17'd0;
        OP_BEAR_T: r_q.bearing_top <= q_one[16:0];
        OP_OFS_DOWN: r_q.offset_down <= (s_q.solid_min_y > s_q.box_min_y) ?
                                        17'd0 - q_one[16:0] : 17'd0;
        OP_ADVANCE: r_q.advance <= q_adv[20:0];
        default: r_q.advance <= r_q.advance;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/glyph_cell_bounding_box_unit.sv */
`default_nettype none
// Glyph cell bounding box unit. Accepts one pixel byte per word (scan order:
// cell by cell, column by column, top to bottom) and emits one glyph record
// word per finished cell, with is_empty on tuser. The scan front takes a pixel
// every cycle unless its registered cell summary still waits for the two-entry
// queue, which hands summaries to the metric back end; that runs ten Q16
// divisions on one shared bit-serial divider. A non-empty record is valid once
// all ten divisions are done; an empty one skips them. The back end is free
// again in the cycle after its record is taken. Up to four finished cells wait
// inside (back end, queue, scan register), so cells long enough to cover the
// divisions stream at one pixel per cycle; back-to-back smaller cells stall the
// input. Write the configuration only while no cell is in flight; writes are
// taken in any cycle.
module glyph_cell_bounding_box_unit #(
  parameter int unsigned GLYPH_COUNT = 128
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // sample
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // glyph_index, u_pos, v_pos, u_size, v_size, width_ratio, height_ratio,
  // bearing_left, bearing_top, offset_down, advance; pad to 216
  output logic [215:0]      m_axis_tdata,
  output logic              m_axis_tuser,   // is_empty
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i
);

  logic [12:0] aw_q, ah_q;
  logic [8:0]  cw_q, ch_q;
  logic [7:0]  cols_q, cov_q, sol_q;
  logic [15:0] adv_q;
  gcbb_pkg::geom_t geom;
  gcbb_pkg::cell_sum_t sum, qsum;
  gcbb_pkg::glyph_rec_t rec;
  logic sv, sr, qv, qr;
  logic [7:0] cols_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q <= 13'd512; ah_q <= 13'd512;
      cw_q <= gcbb_pkg::CELL_W_RST; ch_q <= gcbb_pkg::CELL_H_RST;
      cols_q <= 8'd16; cov_q <= 8'd20; sol_q <= 8'd200; adv_q <= 16'd36045;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gcbb_pkg::REG_ATLAS_W:   aw_q <= cfg_data_i[12:0];
        gcbb_pkg::REG_ATLAS_H:   ah_q <= cfg_data_i[12:0];
        gcbb_pkg::REG_CELL_W:    cw_q <= cfg_data_i[8:0];
        gcbb_pkg::REG_CELL_H:    ch_q <= cfg_data_i[8:0];
        gcbb_pkg::REG_COLUMNS:   cols_q <= cfg_data_i[7:0];
        gcbb_pkg::REG_COV_TH:    cov_q <= cfg_data_i[7:0];
        gcbb_pkg::REG_SOLID:     sol_q <= cfg_data_i[7:0];
        gcbb_pkg::REG_ADV_SCALE: adv_q <= cfg_data_i;
        default: adv_q <= adv_q;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    geom.aw = (aw_q == 13'd0) ? 13'd1 : (aw_q > 13'd4096 ? 13'd4096 : aw_q);
    geom.ah = (ah_q == 13'd0) ? 13'd1 : (ah_q > 13'd4096 ? 13'd4096 : ah_q);
    geom.cw = (cw_q == 9'd0) ? 9'd1 : (cw_q > 9'd256 ? 9'd256 : cw_q);
    geom.ch = (ch_q == 9'd0) ? 9'd1 : (ch_q > 9'd256 ? 9'd256 : ch_q);
    geom.adv_scale = adv_q;
    cols_e = (cols_q == 8'd0) ? 8'd1 : (cols_q > 8'd128 ? 8'd128 : cols_q);
  end

  gcbb_scan #(.GLYPH_COUNT(GLYPH_COUNT)) u_scan (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .sample_i(s_axis_tdata), .cw_i(geom.cw), .ch_i(geom.ch), .cols_i(cols_e),
    .cov_th_i(cov_q), .solid_i(sol_q), .sum_valid_o(sv), .sum_ready_i(sr),
    .sum_o(sum));

  gcbb_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(sv), .wr_ready_o(sr), .wr_data_i(sum),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qsum));

  gcbb_metric u_metric (
    .clk_i, .rst_ni, .sum_valid_i(qv), .sum_ready_o(qr), .sum_i(qsum),
    .geom_i(geom), .rec_valid_o(m_axis_tvalid), .rec_ready_i(m_axis_tready),
    .rec_o(rec));

  assign m_axis_tdata = {5'd0, rec.advance, rec.offset_down, rec.bearing_top,
                         rec.bearing_left, rec.height_ratio, rec.width_ratio,
                         rec.v_size, rec.u_size, rec.v_pos, rec.u_pos,
                         rec.glyph_index};
  assign m_axis_tuser = rec.is_empty;

endmodule
`default_nettype wire
